[hdl/two_digit_display_animator_unit_macros.svh]
// Assertion macros for the two-digit display animator.
// Used by the checker module; depends on nothing else.
`ifndef TWO_DIGIT_DISPLAY_ANIMATOR_UNIT_MACROS_SVH
`define TWO_DIGIT_DISPLAY_ANIMATOR_UNIT_MACROS_SVH

// Checked at every edge outside reset.
`define TDDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define TDDA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tdda_pkg.sv]
// Shared types, constants and helper functions for the two-digit display animator.
// Depends on nothing; the interfaces, divider, top level and checker use scoped names, the testbench imports it.
`default_nettype none

package tdda_pkg;

    localparam int VAL_W      = 7;
    localparam int DIGIT_W    = 4;
    localparam int TICK_W     = 20;
    localparam int PER_W      = 16;
    localparam int ACT_W      = 3;
    localparam int STEP_W     = 3;
    localparam int DVD_W      = VAL_W + TICK_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int SPIN_STEPS = 8;

    localparam logic [VAL_W-1:0]  VALUE_MAX   = VAL_W'(99);
    localparam logic [TICK_W-1:0] ELAPSED_MAX = '1;
    localparam logic [PER_W-1:0]  SINCE_MAX   = '1;
    localparam logic [TICK_W-1:0] TEN_DIVISOR = TICK_W'(10);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(SPIN_STEPS - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK        = 3'd0,
        ACT_START_COUNT = 3'd1,
        ACT_SPIN_CW     = 3'd2,
        ACT_SPIN_CCW    = 3'd3,
        ACT_STOP        = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_CW    = 2'd2,
        MODE_CCW   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_TOTAL = 2'd1,
        S_QUOT  = 2'd2,
        S_EMIT  = 2'd3
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TICK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    // Values above ninety-nine are pinned to ninety-nine.
    function automatic logic [VAL_W-1:0] clamp_value(input logic [VAL_W-1:0] v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    // Split a value of at most 99 into decimal digits. Multiplying by 205 and
    // dropping 11 bits divides by ten exactly for every value below 180.
    function automatic digits_t to_digits(input logic [VAL_W-1:0] v);
        logic [14:0]        prod;
        logic [VAL_W-1:0]   tens_x10;
        logic [VAL_W-1:0]   rest;
        digits_t            d;
        prod     = 15'(v) * 15'd205;
        d.tens   = prod[14:11];
        tens_x10 = VAL_W'(d.tens) * VAL_W'(10);
        rest     = v - tens_x10;
        d.ones   = rest[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/tdda_cmd_if.sv]
// Command channel of the two-digit display animator: handshake and input fields.
// Depends on tdda_pkg for field widths.
`default_nettype none

interface tdda_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tdda_pkg::ACT_W-1:0] action;
    logic [tdda_pkg::VAL_W-1:0] from_value;
    logic [tdda_pkg::VAL_W-1:0] to_value;
    logic [tdda_pkg::PER_W-1:0] per_ten_duration;
    logic [tdda_pkg::PER_W-1:0] step_period;

    modport source (
        output valid, action, from_value, to_value, per_ten_duration, step_period,
        input  ready
    );
    modport sink (
        input  valid, action, from_value, to_value, per_ten_duration, step_period,
        output ready
    );
endinterface

`default_nettype wire

[hdl/tdda_res_if.sv]
// Result channel of the two-digit display animator: handshake and output fields.
// Depends on tdda_pkg for field widths.
`default_nettype none

interface tdda_res_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tdda_pkg::DIGIT_W-1:0] tens_digit;
    logic [tdda_pkg::DIGIT_W-1:0] ones_digit;
    logic [tdda_pkg::STEP_W-1:0]  spin_step;
    logic                         finished;

    modport source (
        output valid, kind, tens_digit, ones_digit, spin_step, finished,
        input  ready
    );
    modport sink (
        input  valid, kind, tens_digit, ones_digit, spin_step, finished,
        output ready
    );
endinterface

`default_nettype wire

[hdl/tdda_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on tdda_pkg for widths and the request and response structs.
`default_nettype none

module tdda_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tdda_pkg::div_req_t req,
    output tdda_pkg::div_rsp_t      rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [tdda_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [tdda_pkg::TICK_W-1:0]      rem_reg;
    logic [tdda_pkg::TICK_W-1:0]      dsr_reg;
    logic [tdda_pkg::DVD_W-1:0]       quo_reg;

    logic [tdda_pkg::TICK_W:0]        trial;
    logic [tdda_pkg::TICK_W:0]        diff;
    logic                             fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[tdda_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= tdda_pkg::DIV_CNT_W'(tdda_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != tdda_pkg::DIV_CNT_W'(1));
            done_reg <= (cnt_reg == tdda_pkg::DIV_CNT_W'(1));
            cnt_reg  <= cnt_reg - tdda_pkg::DIV_CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dsr_reg <= req.divisor;
            quo_reg <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[tdda_pkg::TICK_W-1:0] : trial[tdda_pkg::TICK_W-1:0];
            quo_reg <= {quo_reg[tdda_pkg::DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[hdl/two_digit_display_animator_unit.sv]
// Top level of the two-digit display animator: sequencer, animation state and
// output register. Depends on tdda_pkg, tdda_cmd_if, tdda_res_if and tdda_divider.
//
//  Channel | Direction | Transaction carries
//  --------+-----------+---------------------------------------------------------
//  cmd     | in        | action, from_value, to_value, per_ten_duration, step_period
//  res     | out       | kind, tens_digit, ones_digit, spin_step, finished
//
// Spin, stop and ignored commands leave the sequencer idle. A start-count command
// holds it in S_TOTAL, and a count tick that does not finish in S_QUOT, until the
// serial divider is done; the divider resolves one of 27 quotient bits per cycle.
// S_QUOT then moves to S_EMIT; a spin tick or a finishing count tick goes straight there.
// After reset the block is idle and takes commands at once.
// A result waits in the output register while the next command is taken; a new
// result is held back only while that register is still full.
`default_nettype none

module two_digit_display_animator_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tdda_cmd_if.sink     cmd,
    tdda_res_if.source   res
);

    // Sequencer and animation state.
    tdda_pkg::state_t                state_reg, state_next;
    tdda_pkg::mode_t                 mode_reg, mode_next;
    logic [tdda_pkg::VAL_W-1:0]      start_reg, start_next;
    logic [tdda_pkg::VAL_W-1:0]      end_reg, end_next;
    logic [tdda_pkg::VAL_W-1:0]      dist_reg, dist_next;
    logic                            up_reg, up_next;
    logic [tdda_pkg::TICK_W-1:0]     total_reg, total_next;
    logic [tdda_pkg::TICK_W-1:0]     elapsed_reg, elapsed_next;
    logic [tdda_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [tdda_pkg::PER_W-1:0]      since_reg, since_next;
    logic [tdda_pkg::PER_W-1:0]      period_reg, period_next;

    // Result waiting for the output register.
    logic                            rslt_kind_reg, rslt_kind_next;
    tdda_pkg::digits_t               rslt_dig_reg, rslt_dig_next;
    logic [tdda_pkg::STEP_W-1:0]     rslt_step_reg, rslt_step_next;
    logic                            rslt_fin_reg, rslt_fin_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic                            out_kind_reg, out_kind_next;
    tdda_pkg::digits_t               out_dig_reg, out_dig_next;
    logic [tdda_pkg::STEP_W-1:0]     out_step_reg, out_step_next;
    logic                            out_fin_reg, out_fin_next;

    // Decoded command and shared datapath.
    tdda_pkg::action_t               act;
    logic                            cmd_fire;
    logic                            out_free;
    logic [tdda_pkg::VAL_W-1:0]      from_cl;
    logic [tdda_pkg::VAL_W-1:0]      to_cl;
    logic                            up_in;
    logic [tdda_pkg::VAL_W-1:0]      dist_in;
    logic [tdda_pkg::TICK_W-1:0]     elapsed_inc;
    logic                            count_done;
    logic [tdda_pkg::PER_W-1:0]      since_inc;
    logic                            is_start;
    logic                            tick_div;
    logic [tdda_pkg::TICK_W-1:0]     mul_a;
    logic [tdda_pkg::VAL_W-1:0]      mul_b;
    logic [tdda_pkg::DVD_W-1:0]      mul_prod;
    logic [tdda_pkg::VAL_W-1:0]      quot_val;
    logic [tdda_pkg::VAL_W-1:0]      shown;
    tdda_pkg::div_req_t              div_req;
    tdda_pkg::div_rsp_t              div_rsp;

    assign act      = tdda_pkg::action_t'(cmd.action);
    assign cmd_fire = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || res.ready;

    // Command values are pinned to ninety-nine before anything uses them.
    assign from_cl = tdda_pkg::clamp_value(cmd.from_value);
    assign to_cl   = tdda_pkg::clamp_value(cmd.to_value);
    assign up_in   = (to_cl >= from_cl);
    assign dist_in = up_in ? (to_cl - from_cl) : (from_cl - to_cl);

    // Both counters saturate instead of wrapping.
    assign elapsed_inc = (elapsed_reg == tdda_pkg::ELAPSED_MAX) ?
                         elapsed_reg : (elapsed_reg + tdda_pkg::TICK_W'(1));
    assign since_inc   = (since_reg == tdda_pkg::SINCE_MAX) ?
                         since_reg : (since_reg + tdda_pkg::PER_W'(1));
    assign count_done  = (elapsed_inc >= total_reg);

    // The divider runs in two places. A start-count command divides
    // distance times per-ten duration by ten to get the total tick count. A
    // count tick that has not reached the end divides elapsed times distance
    // by the total to get the interpolated offset. One multiplier feeds both,
    // and its product is registered inside the divider.
    assign is_start = (act == tdda_pkg::ACT_START_COUNT);
    assign tick_div = (act == tdda_pkg::ACT_TICK) &&
                      (mode_reg == tdda_pkg::MODE_COUNT) && !count_done;
    assign mul_a    = is_start ? tdda_pkg::TICK_W'(cmd.per_ten_duration) : elapsed_inc;
    assign mul_b    = is_start ? dist_in : dist_reg;
    assign mul_prod = tdda_pkg::DVD_W'(mul_a) * tdda_pkg::DVD_W'(mul_b);

    // Offset is below the distance because elapsed is below the total.
    assign quot_val = div_rsp.quotient[tdda_pkg::VAL_W-1:0];
    assign shown    = up_reg ? (start_reg + quot_val) : (start_reg - quot_val);

    tdda_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdda_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (is_start)
                    begin
                        state_next = tdda_pkg::S_TOTAL;
                    end
                    else if (act == tdda_pkg::ACT_TICK && mode_reg != tdda_pkg::MODE_IDLE)
                    begin
                        state_next = tick_div ? tdda_pkg::S_QUOT : tdda_pkg::S_EMIT;
                    end
                end
            end
            tdda_pkg::S_TOTAL:
            begin
                if (div_rsp.done)
                begin
                    state_next = tdda_pkg::S_IDLE;
                end
            end
            tdda_pkg::S_QUOT:
            begin
                if (div_rsp.done)
                begin
                    state_next = tdda_pkg::S_EMIT;
                end
            end
            tdda_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tdda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdda_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: command ready and the divider launch.
    always_comb
    begin
        cmd.ready        = (state_reg == tdda_pkg::S_IDLE);
        div_req.start    = cmd_fire && (is_start || tick_div);
        div_req.dividend = mul_prod;
        div_req.divisor  = is_start ? tdda_pkg::TEN_DIVISOR : total_reg;
    end

    // Animation state, pending result and output register.
    always_comb
    begin
        mode_next      = mode_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        dist_next      = dist_reg;
        up_next        = up_reg;
        total_next     = total_reg;
        elapsed_next   = elapsed_reg;
        step_next      = step_reg;
        since_next     = since_reg;
        period_next    = period_reg;
        rslt_kind_next = rslt_kind_reg;
        rslt_dig_next  = rslt_dig_reg;
        rslt_step_next = rslt_step_reg;
        rslt_fin_next  = rslt_fin_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_dig_next   = out_dig_reg;
        out_step_next  = out_step_reg;
        out_fin_next   = out_fin_reg;

        case (state_reg)
            tdda_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (act)
                        tdda_pkg::ACT_START_COUNT:
                        begin
                            start_next   = from_cl;
                            end_next     = to_cl;
                            dist_next    = dist_in;
                            up_next      = up_in;
                            elapsed_next = '0;
                            mode_next    = tdda_pkg::MODE_COUNT;
                        end
                        tdda_pkg::ACT_SPIN_CW:
                        begin
                            period_next = cmd.step_period;
                            since_next  = '0;
                            step_next   = '0;
                            mode_next   = tdda_pkg::MODE_CW;
                        end
                        tdda_pkg::ACT_SPIN_CCW:
                        begin
                            period_next = cmd.step_period;
                            since_next  = '0;
                            step_next   = tdda_pkg::STEP_LAST;
                            mode_next   = tdda_pkg::MODE_CCW;
                        end
                        tdda_pkg::ACT_STOP:
                        begin
                            mode_next = tdda_pkg::MODE_IDLE;
                        end
                        tdda_pkg::ACT_TICK:
                        begin
                            if (mode_reg == tdda_pkg::MODE_COUNT)
                            begin
                                elapsed_next = elapsed_inc;
                                if (count_done)
                                begin
                                    // The count has reached its end value.
                                    rslt_kind_next = 1'b0;
                                    rslt_dig_next  = tdda_pkg::to_digits(end_reg);
                                    rslt_step_next = '0;
                                    rslt_fin_next  = 1'b1;
                                    mode_next      = tdda_pkg::MODE_IDLE;
                                end
                            end
                            else if (mode_reg != tdda_pkg::MODE_IDLE)
                            begin
                                elapsed_next = elapsed_inc;
                                since_next   = since_inc;
                                if (since_inc >= period_reg)
                                begin
                                    since_next = '0;
                                    if (mode_reg == tdda_pkg::MODE_CW)
                                    begin
                                        step_next = (step_reg == tdda_pkg::STEP_LAST) ?
                                                    '0 : (step_reg + tdda_pkg::STEP_W'(1));
                                    end
                                    else
                                    begin
                                        step_next = (step_reg == '0) ?
                                                    tdda_pkg::STEP_LAST :
                                                    (step_reg - tdda_pkg::STEP_W'(1));
                                    end
                                end
                                rslt_kind_next = 1'b1;
                                rslt_dig_next  = '0;
                                rslt_step_next = step_next;
                                rslt_fin_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Unused action codes change nothing.
                        end
                    endcase
                end
            end
            tdda_pkg::S_TOTAL:
            begin
                if (div_rsp.done)
                begin
                    total_next = div_rsp.quotient[tdda_pkg::TICK_W-1:0];
                end
            end
            tdda_pkg::S_QUOT:
            begin
                if (div_rsp.done)
                begin
                    rslt_kind_next = 1'b0;
                    rslt_dig_next  = tdda_pkg::to_digits(shown);
                    rslt_step_next = '0;
                    rslt_fin_next  = 1'b0;
                end
            end
            tdda_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = rslt_kind_reg;
                    out_dig_next   = rslt_dig_reg;
                    out_step_next  = rslt_step_reg;
                    out_fin_next   = rslt_fin_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdda_pkg::S_IDLE;
            mode_reg      <= tdda_pkg::MODE_IDLE;
            start_reg     <= '0;
            end_reg       <= '0;
            dist_reg      <= '0;
            up_reg        <= 1'b1;
            total_reg     <= '0;
            elapsed_reg   <= '0;
            step_reg      <= '0;
            since_reg     <= '0;
            period_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            dist_reg      <= dist_next;
            up_reg        <= up_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            step_reg      <= step_next;
            since_reg     <= since_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        rslt_kind_reg <= rslt_kind_next;
        rslt_dig_reg  <= rslt_dig_next;
        rslt_step_reg <= rslt_step_next;
        rslt_fin_reg  <= rslt_fin_next;
        out_kind_reg  <= out_kind_next;
        out_dig_reg   <= out_dig_next;
        out_step_reg  <= out_step_next;
        out_fin_reg   <= out_fin_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = out_kind_reg;
    assign res.tens_digit = out_dig_reg.tens;
    assign res.ones_digit = out_dig_reg.ones;
    assign res.spin_step  = out_step_reg;
    assign res.finished   = out_fin_reg;

endmodule

`default_nettype wire

[hdl/tdda_checker.sv]
// Port-level assertions for the two-digit display animator, bound to the top level.
// Depends on tdda_pkg and the assertion macros header.
`default_nettype none

`include "two_digit_display_animator_unit_macros.svh"

module tdda_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         cmd_valid,
    input wire logic                         cmd_ready,
    input wire logic [tdda_pkg::ACT_W-1:0]   cmd_action,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic                         res_kind,
    input wire logic [tdda_pkg::DIGIT_W-1:0] res_tens_digit,
    input wire logic [tdda_pkg::DIGIT_W-1:0] res_ones_digit,
    input wire logic                         res_finished
);

    // No result is offered while reset is held.
    `TDDA_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !res_valid, "result valid in reset")

    // A result that is not taken stays offered.
    `TDDA_ASSERT(a_res_held, clk, rst_n, res_valid && !res_ready |=> res_valid, "result dropped")

    // Digits are decimal, and a spinner transaction carries neither digits nor finish.
    `TDDA_ASSERT(a_digits_ok, clk, rst_n, res_valid |-> (res_tens_digit <= 4'd9) && (res_ones_digit <= 4'd9) && !(res_kind && (res_finished || res_tens_digit != 4'd0 || res_ones_digit != 4'd0)), "bad result fields")

    // Spin and stop commands complete at once, so the next command is taken.
    `TDDA_ASSERT(a_quick_cmd, clk, rst_n, cmd_valid && cmd_ready && (cmd_action == tdda_pkg::ACT_SPIN_CW || cmd_action == tdda_pkg::ACT_SPIN_CCW || cmd_action == tdda_pkg::ACT_STOP) |=> cmd_ready, "not ready after quick command")

endmodule

bind two_digit_display_animator_unit tdda_checker u_tdda_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_action     (cmd.action),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_kind       (res.kind),
    .res_tens_digit (res.tens_digit),
    .res_ones_digit (res.ones_digit),
    .res_finished   (res.finished)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for two_digit_display_animator_unit.
// Depends on tdda_pkg, tdda_cmd_if, tdda_res_if and the unit itself.
`default_nettype none

module testbench;
    import tdda_pkg::*;

    // The longest correct quiet stretch is the deliberate result hold-off
    // below plus one divider pass; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 4000;
    // A start-count command keeps the divider busy for a whole pass
    // without producing a result, so the drain waits well beyond one pass.
    localparam int DRAIN_CYCLES   = 80;
    localparam int IDLE_PERCENT   = 18;
    localparam int PRESSURE_HOLD  = 400;
    localparam int SHOWN_MAX      = 99;
    localparam int LONG_COUNT     = 150;

    // Action codes 5 to 7 are not decoded and must be ignored by the block.
    localparam logic [ACT_W-1:0] ACT_RESERVED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RESERVED_HI = 3'd7;
    localparam logic [VAL_W-1:0] VAL_FIELD_MAX   = '1;
    localparam logic [PER_W-1:0] PER_FIELD_MAX   = '1;

    // One display frame as it appears on the result channel.
    typedef struct packed {
        logic               kind;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        logic [STEP_W-1:0]  step;
        logic               finished;
    } display_frame_t;

    logic clk;
    logic rst_n;

    tdda_cmd_if cmd ();
    tdda_res_if res ();

    two_digit_display_animator_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // Frames the block owes us, oldest first.
    display_frame_t frames_due[$];

    // Our own copy of the animation state, advanced on every accepted command.
    mode_t              anim_mode;
    logic [VAL_W-1:0]   anim_from;
    logic [VAL_W-1:0]   anim_to;
    logic [TICK_W-1:0]  anim_total;
    logic [TICK_W-1:0]  anim_elapsed;
    logic [STEP_W-1:0]  spin_index;
    logic [PER_W-1:0]   spin_since;
    logic [PER_W-1:0]   spin_period;

    int  commands_sent  = 0;
    int  frames_checked = 0;
    int  counts_started = 0;
    int  spins_started  = 0;
    int  mismatches     = 0;
    int  stalled_cycles = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  cmd_idling     = 1'b1;
    bit  res_idling     = 1'b1;

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Prints one line per mismatch and keeps the tally for the final verdict.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] MISMATCH on frame %0d: %s got %0d, expected %0d",
                 $realtime, frames_checked, what, got, want);
    endtask

    // Advances the predicted animation by one accepted command transaction and
    // queues the frame it should produce, if any. Other actions never produce a frame;
    // a tick produces one unless the display is idle.
    task automatic advance_display_model(input logic [ACT_W-1:0] act,
                                         input logic [VAL_W-1:0] from_v,
                                         input logic [VAL_W-1:0] to_v,
                                         input logic [PER_W-1:0] per_ten,
                                         input logic [PER_W-1:0] period_v);
        logic [VAL_W-1:0] span;
        logic [63:0]      moved;
        int               shown;
        display_frame_t   frame;
        frame = '0;
        case (act)
            ACT_START_COUNT:
            begin
                // Values above ninety-nine are pinned when captured.
                anim_from    = (from_v > SHOWN_MAX) ? VAL_W'(SHOWN_MAX) : from_v;
                anim_to      = (to_v > SHOWN_MAX) ? VAL_W'(SHOWN_MAX) : to_v;
                span         = (anim_to >= anim_from) ? anim_to - anim_from
                                                      : anim_from - anim_to;
                anim_total   = TICK_W'((64'(span) * 64'(per_ten)) / 64'd10);
                anim_elapsed = '0;
                anim_mode    = MODE_COUNT;
                counts_started++;
            end
            ACT_SPIN_CW, ACT_SPIN_CCW:
            begin
                spin_period = period_v;
                spin_since  = '0;
                spin_index  = (act == ACT_SPIN_CW) ? '0 : STEP_W'(SPIN_STEPS - 1);
                anim_mode   = (act == ACT_SPIN_CW) ? MODE_CW : MODE_CCW;
                spins_started++;
            end
            ACT_STOP:
                anim_mode = MODE_IDLE;
            ACT_TICK:
            begin
                if (anim_mode == MODE_COUNT)
                begin
                    if (anim_elapsed != '1)
                        anim_elapsed++;
                    if (anim_elapsed >= anim_total)
                    begin
                        // The count has arrived: show the end value and go idle.
                        shown          = anim_to;
                        frame.finished = 1'b1;
                        anim_mode      = MODE_IDLE;
                    end
                    else
                    begin
                        span  = (anim_to >= anim_from) ? anim_to - anim_from
                                                       : anim_from - anim_to;
                        moved = (64'(anim_elapsed) * 64'(span)) / 64'(anim_total);
                        shown = (anim_to >= anim_from) ? anim_from + int'(moved)
                                                       : anim_from - int'(moved);
                    end
                    frame.kind = 1'b0;
                    frame.tens = DIGIT_W'(shown / 10);
                    frame.ones = DIGIT_W'(shown % 10);
                    frames_due.push_back(frame);
                end
                else if (anim_mode == MODE_CW || anim_mode == MODE_CCW)
                begin
                    if (spin_since != '1)
                        spin_since++;
                    if (spin_since >= spin_period)
                    begin
                        spin_since = '0;
                        if (anim_mode == MODE_CW)
                            spin_index = STEP_W'((spin_index + 1) % SPIN_STEPS);
                        else
                            spin_index = STEP_W'((spin_index + SPIN_STEPS - 1) % SPIN_STEPS);
                    end
                    frame.kind = 1'b1;
                    frame.step = spin_index;
                    frames_due.push_back(frame);
                end
            end
            default:
            begin
                // Reserved action codes leave the state alone.
            end
        endcase
    endtask

    // Offers one command transaction, driven on the falling edge, and waits for
    // the rising edge at which the block takes it. Valid stays high afterwards so
    // that back-to-back transactions need no idle gap.
    task automatic send_command(input logic [ACT_W-1:0] act,
                                input logic [VAL_W-1:0] from_v,
                                input logic [VAL_W-1:0] to_v,
                                input logic [PER_W-1:0] per_ten,
                                input logic [PER_W-1:0] period_v);
        int gap;
        @(negedge clk);
        if (cmd_idling && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = $urandom_range(1, 3);
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid            <= 1'b1;
        cmd.action           <= act;
        cmd.from_value       <= from_v;
        cmd.to_value         <= to_v;
        cmd.per_ten_duration <= per_ten;
        cmd.step_period      <= period_v;
        do
            @(posedge clk);
        while (!cmd.ready);
        commands_sent++;
        advance_display_model(act, from_v, to_v, per_ten, period_v);
    endtask

    // A tick carries random junk in the fields it does not use.
    task automatic send_tick();
        send_command(ACT_TICK, VAL_W'($urandom), VAL_W'($urandom),
                     PER_W'($urandom), PER_W'($urandom));
    endtask

    // Extremes of every field, every action, and the named corner cases:
    // ticks while idle, reserved codes, zero distance, zero duration, clamping,
    // the largest total, descending counts and commands that cut in.
    task automatic test_directed_corners();
        send_tick();
        send_command(ACT_RESERVED_LO, VAL_FIELD_MAX, '0, PER_FIELD_MAX, '0);
        send_command(ACT_RESERVED_HI, '0, VAL_FIELD_MAX, '0, PER_FIELD_MAX);
        send_command(ACT_STOP, '0, '0, '0, '0);
        // Zero duration: the first tick finishes.
        send_command(ACT_START_COUNT, '0, VAL_W'(SHOWN_MAX), '0, '0);
        send_tick();
        // Zero distance with the longest duration.
        send_command(ACT_START_COUNT, VAL_W'(42), VAL_W'(42), PER_FIELD_MAX, '0);
        send_tick();
        // Start value above ninety-nine counting down.
        send_command(ACT_START_COUNT, VAL_FIELD_MAX, '0, PER_W'(10), '0);
        send_tick();
        // Largest total, then cut off by a spinner.
        send_command(ACT_START_COUNT, VAL_W'(SHOWN_MAX), '0, PER_FIELD_MAX, '0);
        send_tick();
        send_command(ACT_SPIN_CW, '0, '0, '0, '0);
        send_tick();
        send_tick();
        send_command(ACT_SPIN_CCW, '0, '0, '0, PER_FIELD_MAX);
        send_tick();
        // Counterclockwise with a zero period steps on every tick.
        send_command(ACT_SPIN_CCW, '0, '0, '0, '0);
        send_tick();
        send_command(ACT_STOP, '0, '0, '0, '0);
        send_tick();
        // A short count run all the way to its end.
        send_command(ACT_START_COUNT, VAL_W'(10), VAL_W'(15), PER_W'(10), '0);
        repeat (6) send_tick();
    endtask

    // Count animations with random end points; most run to completion and up to three
    // ticks past it, the rest are cut off by the next command.
    task automatic test_count_sequences(input int budget);
        int               stop_at;
        int               burst;
        logic [PER_W-1:0] per_ten;
        stop_at = commands_sent + budget;
        while (commands_sent < stop_at)
        begin
            per_ten = ($urandom_range(0, 99) < 85) ? PER_W'($urandom_range(0, 12))
                                                   : PER_W'($urandom);
            send_command(ACT_START_COUNT, VAL_W'($urandom), VAL_W'($urandom),
                         per_ten, PER_W'($urandom));
            if ($urandom_range(0, 99) < 70 && anim_total < LONG_COUNT)
                burst = anim_total + 1 + $urandom_range(0, 2);
            else
                burst = $urandom_range(1, 12);
            repeat (burst) send_tick();
        end
    endtask

    // Spinners in both directions, mostly with short periods so that steps and
    // wraps are frequent, now and then with a period anywhere in the field.
    task automatic test_spin_sequences(input int budget);
        int               stop_at;
        int               pick;
        logic [PER_W-1:0] period_v;
        logic [ACT_W-1:0] act;
        stop_at = commands_sent + budget;
        while (commands_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                period_v = PER_W'($urandom_range(0, 6));
            else if (pick < 90)
                period_v = PER_W'($urandom_range(0, 40));
            else
                period_v = PER_W'($urandom);
            act = $urandom_range(0, 1) ? ACT_SPIN_CW : ACT_SPIN_CCW;
            send_command(act, VAL_W'($urandom), VAL_W'($urandom),
                         PER_W'($urandom), period_v);
            repeat ($urandom_range(1, 30)) send_tick();
        end
    endtask

    // Unstructured traffic: any action code with any field values, weighted
    // toward ticks so that stops and reserved codes land mid-animation.
    task automatic test_random_noise(input int budget);
        int               stop_at;
        logic [ACT_W-1:0] act;
        stop_at = commands_sent + budget;
        while (commands_sent < stop_at)
        begin
            act = ($urandom_range(0, 99) < 50) ? ACT_TICK
                                               : ACT_W'($urandom_range(0, 7));
            send_command(act, VAL_W'($urandom), VAL_W'($urandom),
                         PER_W'($urandom), PER_W'($urandom));
        end
    endtask

    // The receiver holds ready low for a long stretch while ticks keep coming,
    // so the output register fills and the block must push back on commands.
    task automatic test_result_backpressure();
        send_command(ACT_SPIN_CW, '0, '0, '0, '0);
        hold_request = PRESSURE_HOLD;
        repeat (20) send_tick();
        send_command(ACT_START_COUNT, '0, VAL_W'(SHOWN_MAX), PER_W'(2), '0);
        repeat (22) send_tick();
    endtask

    // Back-to-back transactions with neither side ever idling.
    task automatic test_steady_stream();
        cmd_idling = 1'b0;
        res_idling = 1'b0;
        test_count_sequences(80);
        test_spin_sequences(70);
        cmd_idling = 1'b1;
        res_idling = 1'b1;
    endtask

    // Result ready, changed on the falling edge. A hold-off requested by a test
    // is counted down here, one cycle at a time.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= !(res_idling && $urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Every accepted result is compared field by field with the oldest frame due.
    always @(posedge clk)
    begin : check_frames
        display_frame_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (frames_due.size() == 0)
                report_mismatch("result with no frame due, kind", res.kind, 0);
            else
            begin
                want = frames_due.pop_front();
                if (res.kind !== want.kind)
                    report_mismatch("kind", res.kind, want.kind);
                if (res.tens_digit !== want.tens)
                    report_mismatch("tens_digit", res.tens_digit, want.tens);
                if (res.ones_digit !== want.ones)
                    report_mismatch("ones_digit", res.ones_digit, want.ones);
                if (res.spin_step !== want.step)
                    report_mismatch("spin_step", res.spin_step, want.step);
                if (res.finished !== want.finished)
                    report_mismatch("finished", res.finished, want.finished);
            end
            frames_checked++;
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d frames still due",
                         stalled_cycles, frames_due.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        // Every input known from time zero; the block is held in reset.
        rst_n                = 1'b0;
        cmd.valid            = 1'b0;
        cmd.action           = ACT_TICK;
        cmd.from_value       = '0;
        cmd.to_value         = '0;
        cmd.per_ten_duration = '0;
        cmd.step_period      = '0;
        res.ready            = 1'b0;

        // The model matches the block's reset state.
        anim_mode    = MODE_IDLE;
        anim_from    = '0;
        anim_to      = '0;
        anim_total   = '0;
        anim_elapsed = '0;
        spin_index   = '0;
        spin_since   = '0;
        spin_period  = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_count_sequences(600);
        test_spin_sequences(400);
        test_random_noise(220);
        test_result_backpressure();
        test_steady_stream();

        @(negedge clk);
        cmd.valid <= 1'b0;

        // Wait for every owed frame, then for any late or extra result.
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command transactions (%0d counts, %0d spinners started).",
                 commands_sent, counts_started, spins_started);
        $display("Checked %0d result transactions, %0d mismatches.",
                 frames_checked, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

[two_digit_display_animator_unit.f]
+incdir+hdl
hdl/tdda_pkg.sv
hdl/tdda_cmd_if.sv
hdl/tdda_res_if.sv
hdl/tdda_divider.sv
hdl/two_digit_display_animator_unit.sv
hdl/tdda_checker.sv
dv/testbench.sv
